### src/mats_pkg.sv
package mats_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam int SLOT_W   = 3;
  localparam int PERIOD_W = 31;
  localparam int NOW_W    = 63;
  localparam int TIME_W   = 64;
  localparam int MASK_W   = 8;
  localparam int WAIT_W   = 22;

  localparam int MASK_IDX_W = $clog2(MASK_W);

  // Longest host interval in ms, and the distance in us from which it applies.
  localparam logic [WAIT_W-1:0] WAIT_MAX = 22'd2147483;
  localparam logic [TIME_W-1:0] SAT_US   = 64'd2147484000;

  // Division by 1000 as (x * DIV_MAGIC) >> DIV_SHIFT, exact for every 32-bit x.
  localparam int              DIV_IN_W  = 32;
  localparam int              MAGIC_W   = 29;
  localparam int              PROD_W    = DIV_IN_W + MAGIC_W;
  localparam int              DIV_SHIFT = 38;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'h10624DD3;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period_us;
    logic [NOW_W-1:0]    now_us;
    logic [MASK_W-1:0]   repeat_mask;
  } mats_in_t;

  typedef struct packed {
    logic              pending;
    logic [MASK_W-1:0] fired_mask;
    logic [WAIT_W-1:0] wait_ms;
    logic              host_rearm;
  } mats_out_t;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [PERIOD_W-1:0] period;
  } slot_entry_t;

  typedef struct packed {
    logic [DIV_IN_W-1:0] x;
    logic                force_one;
    logic                saturate;
  } div_req_t;

endpackage

### src/mats_ram.sv
module mats_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/mats_div1000.sv
module mats_div1000 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  mats_pkg::div_req_t              req,
  output logic                            valid,
  output logic [mats_pkg::WAIT_W-1:0]     wait_ms
);
  import mats_pkg::*;

  logic                          v0;
  logic                          v1;
  div_req_t                      req_r;
  logic [PROD_W-1:0]             prod;
  logic                          force_one;
  logic                          saturate;
  logic [PROD_W-DIV_SHIFT-1:0]   quot;

  assign quot = prod[PROD_W-1:DIV_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v0    <= go;
      v1    <= v0;
      valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req;
    prod      <= PROD_W'(req_r.x) * PROD_W'(DIV_MAGIC);
    force_one <= req_r.force_one;
    saturate  <= req_r.saturate;
    // The interval never drops below one millisecond. A saturated distance may not fit
    // the multiplier input, so its quotient is ignored.
    if (force_one) begin
      wait_ms <= WAIT_W'(1);
    end else if (saturate) begin
      wait_ms <= WAIT_MAX;
    end else if (quot == '0) begin
      wait_ms <= WAIT_W'(1);
    end else begin
      wait_ms <= quot[WAIT_W-1:0];
    end
  end

endmodule

### src/multi_alarm_timer_scheduler_unit.sv
// Alarm scheduler: NUM_SLOTS alarm slots share one host timer. A word is taken when start is
// high and busy is low; its single result word appears for exactly one cycle with done high,
// and the receiver cannot hold it off. Stop, query and a start to a slot out of range answer
// in the cycle after the word is taken; a start answers from its START state, or after the
// divider when it reprograms the host timer. A tick walks the slot memory one slot per cycle
// through a three-stage read-modify-write pipeline, then sizes the host interval with a
// three-stage multiply-by-reciprocal divider. Slot deadlines
// and periods live in one synchronous RAM; armed bits are flip-flops cleared by reset.
module multi_alarm_timer_scheduler_unit #(
  parameter int NUM_SLOTS = mats_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mats_pkg::mats_in_t  item,
  output logic                done,
  output mats_pkg::mats_out_t result
);
  import mats_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WALK  = 5'b00100,
    S_FIN   = 5'b01000,
    S_DIV   = 5'b10000
  } state_t;

  state_t state, state_next;

  mats_in_t            cmd;
  logic [TIME_W-1:0]   start_dl;
  logic [NUM_SLOTS-1:0] armed;
  logic [TIME_W-1:0]   host_deadline;
  logic                host_running;

  logic                issuing;
  logic [IDX_W-1:0]    idx;
  logic                rd_v;
  logic [IDX_W-1:0]    rd_idx;
  logic                a_v;
  logic                a_armed;
  logic [IDX_W-1:0]    a_idx;
  logic [TIME_W-1:0]   a_left;
  logic [TIME_W-1:0]   a_dl;
  logic [PERIOD_W-1:0] a_per;
  logic                b_v;
  logic                b_cand;
  logic [TIME_W-1:0]   b_left;
  logic                found;
  logic [TIME_W-1:0]   best_left;
  logic [MASK_W-1:0]   fired;

  logic                accept;
  logic                slot_ok;
  logic [IDX_W-1:0]    slot_idx;
  logic [IDX_W-1:0]    cmd_idx;
  logic [TIME_W-1:0]   cmd_now;
  logic [TIME_W-1:0]   start_gap;
  logic                start_later;
  logic                a_exp;
  logic                a_low;
  logic                a_rep;
  logic                idx_last;
  logic                walk_empty;
  logic                better;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  slot_entry_t         ram_wdata;
  slot_entry_t         ram_rdata;

  logic                div_go;
  div_req_t            div_req;
  logic                div_valid;
  logic [WAIT_W-1:0]   div_wait;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign slot_ok  = 32'(item.slot) < NUM_SLOTS;
  assign slot_idx = IDX_W'(item.slot);
  assign cmd_idx  = IDX_W'(cmd.slot);
  assign cmd_now  = {1'b0, cmd.now_us};

  // The new deadline wins if the host timer is idle or it lies strictly before the current host deadline.
  assign start_gap   = host_deadline - start_dl;
  assign start_later = !host_running || (!start_gap[TIME_W-1] && start_gap != '0);

  // A slot expires when its deadline is reached, judged by the sign of deadline - now.
  assign a_exp = a_armed && (a_left == '0 || a_left[TIME_W-1]);
  assign a_low = 32'(a_idx) < MASK_W;
  assign a_rep = a_low && cmd.repeat_mask[MASK_IDX_W'(a_idx)];

  assign idx_last   = (32'(idx) == NUM_SLOTS - 1);
  assign walk_empty = !issuing && !rd_v && !a_v && !b_v;
  assign better     = !found || ($signed(b_left) < $signed(best_left));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_idx;
    ram_wdata = '{deadline: a_dl + TIME_W'(a_per), period: a_per};
    if (state == S_START) begin
      ram_we    = 1'b1;
      ram_waddr = cmd_idx;
      ram_wdata = '{deadline: start_dl, period: cmd.period_us};
    end else if (a_v && a_exp && a_rep) begin
      ram_we = 1'b1;
    end
  end

  mats_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issuing),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    div_go = (state == S_START && start_later) || (state == S_FIN && found);
    if (state == S_START) begin
      div_req = '{x: DIV_IN_W'(cmd.period_us), force_one: 1'b0, saturate: 1'b0};
    end else begin
      div_req.x         = best_left[DIV_IN_W-1:0];
      div_req.force_one = best_left == '0 || best_left[TIME_W-1];
      div_req.saturate  = !best_left[TIME_W-1] && best_left >= SAT_US;
    end
  end

  mats_div1000 u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .req     (div_req),
    .valid   (div_valid),
    .wait_ms (div_wait)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.func == FUNC_START && slot_ok) begin
            state_next = S_START;
          end else if (item.func == FUNC_TICK) begin
            state_next = S_WALK;
          end
        end
      end
      S_START: state_next = start_later ? S_DIV : S_IDLE;
      S_WALK: begin
        if (walk_empty) begin
          state_next = S_FIN;
        end
      end
      S_FIN: state_next = found ? S_DIV : S_IDLE;
      S_DIV: begin
        if (div_valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      armed        <= '0;
      host_running <= 1'b0;
      done         <= 1'b0;
      issuing      <= 1'b0;
      rd_v         <= 1'b0;
      a_v          <= 1'b0;
      b_v          <= 1'b0;
      found        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      rd_v  <= issuing;
      a_v   <= rd_v;
      b_v   <= a_v;
      if (accept) begin
        if (item.func == FUNC_STOP && slot_ok) begin
          armed[slot_idx] <= 1'b0;
        end
        if (item.func == FUNC_STOP || item.func == FUNC_QUERY ||
            (item.func == FUNC_START && !slot_ok)) begin
          done <= 1'b1;
        end
        if (item.func == FUNC_TICK) begin
          issuing <= 1'b1;
          found   <= 1'b0;
        end
      end
      if (issuing && idx_last) begin
        issuing <= 1'b0;
      end
      if (state == S_START) begin
        armed[cmd_idx] <= 1'b1;
        if (start_later) begin
          host_running <= 1'b1;
        end else begin
          done <= 1'b1;
        end
      end
      if (a_v && a_exp && !a_rep) begin
        armed[a_idx] <= 1'b0;
      end
      if (b_v && b_cand && better) begin
        found <= 1'b1;
      end
      if (state == S_FIN) begin
        host_running <= found;
        if (!found) begin
          done <= 1'b1;
        end
      end
      if (state == S_DIV && div_valid) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= item;
      start_dl <= {1'b0, item.now_us} + TIME_W'(item.period_us);
      fired    <= '0;
      idx      <= '0;
      result   <= '{pending: (item.func == FUNC_QUERY && slot_ok) ? armed[slot_idx] : 1'b0,
                    fired_mask: '0, wait_ms: '0, host_rearm: 1'b0};
    end
    if (issuing) begin
      idx    <= idx + 1'b1;
      rd_idx <= idx;
    end

    a_left  <= ram_rdata.deadline - cmd_now;
    a_dl    <= ram_rdata.deadline;
    a_per   <= ram_rdata.period;
    a_idx   <= rd_idx;
    a_armed <= armed[rd_idx];

    // A repeating slot moves on by one period; its distance to now moves with it.
    b_left <= (a_exp && a_rep) ? a_left + TIME_W'(a_per) : a_left;
    b_cand <= a_armed && !(a_exp && !a_rep);
    if (a_v && a_exp && a_low) begin
      fired[MASK_IDX_W'(a_idx)] <= 1'b1;
    end

    if (b_v && b_cand && better) begin
      best_left <= b_left;
    end

    if (state == S_START && start_later) begin
      host_deadline <= start_dl;
    end
    if (state == S_FIN) begin
      if (found) begin
        host_deadline <= best_left + cmd_now;
      end else begin
        result.fired_mask <= fired;
      end
    end
    if (state == S_DIV && div_valid) begin
      result.fired_mask <= fired;
      result.wait_ms    <= div_wait;
      result.host_rearm <= 1'b1;
    end
  end

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> done || busy)
    else $error("accepted word neither answered nor in progress");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("sequencer returned to idle without a result");

  a_rearm_wait: assert property (@(posedge clk) disable iff (rst)
    done && result.host_rearm |-> result.wait_ms != '0 && host_running)
    else $error("host reprogrammed with a zero interval or not running");

  a_idle_wait: assert property (@(posedge clk) disable iff (rst)
    done && !result.host_rearm |-> result.wait_ms == '0)
    else $error("interval reported without host reprogramming");

endmodule

### sim/multi_alarm_timer_scheduler_unit_test.sv
`timescale 1ns / 100ps

module multi_alarm_timer_scheduler_unit_test;
  import mats_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int RANDOM_WORDS = 1450;

  typedef struct {
    mats_in_t word;
    int       gap;  // idle cycles before the word; negative waits for all results
  } timed_word_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  mats_in_t  item = '0;
  logic      done;
  mats_out_t result;

  multi_alarm_timer_scheduler_unit #(.NUM_SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  always #2 clk = ~clk;

  // Scheduler state as seen by the prediction.
  logic [TIME_W-1:0]   alarm_deadline [SLOTS];
  logic [PERIOD_W-1:0] alarm_period [SLOTS];
  logic                alarm_armed [SLOTS];
  logic [TIME_W-1:0]   host_deadline;
  logic                host_on;

  timed_word_t stim_words[$];
  mats_out_t   awaited_results[$];

  int taken_words;
  int mismatches;
  int func_count [4];
  int firing_ticks;
  int saturated_waits;
  int host_rearms;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      alarm_deadline[i] = '0;
      alarm_period[i] = '0;
      alarm_armed[i] = 1'b0;
    end
    host_deadline = '0;
    host_on = 1'b0;
    taken_words = 0;
    mismatches = 0;
    firing_ticks = 0;
    saturated_waits = 0;
    host_rearms = 0;
    for (int i = 0; i < 4; i++) func_count[i] = 0;
  end

  function automatic mats_out_t alarm_outcome(mats_in_t w);
    mats_out_t           r;
    logic [TIME_W-1:0]   now64, dl, left, key, best_key, best_left, ms;
    logic [PERIOD_W-1:0] q;
    logic                found;
    r = '0;
    now64 = {1'b0, w.now_us};
    found = 1'b0;
    best_key = '0;
    best_left = '0;
    case (w.func)
      FUNC_START: begin
        dl = now64 + {{(TIME_W-PERIOD_W){1'b0}}, w.period_us};
        alarm_period[w.slot] = w.period_us;
        alarm_deadline[w.slot] = dl;
        alarm_armed[w.slot] = 1'b1;
        left = host_deadline - dl;
        // An equal deadline leaves the host timer as it is.
        if (!host_on || (!left[TIME_W-1] && host_deadline != dl)) begin
          host_deadline = dl;
          host_on = 1'b1;
          q = w.period_us / 31'd1000;
          if (q == '0) q = 31'd1;
          r.wait_ms = q[WAIT_W-1:0];
          r.host_rearm = 1'b1;
        end
      end
      FUNC_STOP: alarm_armed[w.slot] = 1'b0;
      FUNC_QUERY: r.pending = alarm_armed[w.slot];
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (alarm_armed[i]) begin
            left = alarm_deadline[i] - now64;
            if (left == '0 || left[TIME_W-1]) begin
              r.fired_mask[i] = 1'b1;
              if (!w.repeat_mask[i]) alarm_armed[i] = 1'b0;
              else begin
                alarm_deadline[i] = alarm_deadline[i] + alarm_period[i];
                left = alarm_deadline[i] - now64;
              end
            end
            if (alarm_armed[i]) begin
              // Flipping the sign bit turns signed order into unsigned order.
              key = left ^ {1'b1, {(TIME_W-1){1'b0}}};
              if (!found || key < best_key) begin
                best_key = key;
                best_left = left;
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          host_deadline = best_left + now64;
          host_on = 1'b1;
          if (best_left == '0 || best_left[TIME_W-1]) ms = 64'd1;
          else begin
            ms = best_left / 64'd1000;
            if (ms == '0) ms = 64'd1;
            if (ms > WAIT_MAX) ms = TIME_W'(WAIT_MAX);
          end
          r.wait_ms = ms[WAIT_W-1:0];
          r.host_rearm = 1'b1;
        end else begin
          host_on = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [NOW_W-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[NOW_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic mats_in_t mk(func_t f, int s, logic [PERIOD_W-1:0] p,
                                  logic [NOW_W-1:0] t, logic [MASK_W-1:0] m);
    mats_in_t w;
    w.func = f;
    w.slot = s[SLOT_W-1:0];
    w.period_us = p;
    w.now_us = t;
    w.repeat_mask = m;
    return w;
  endfunction

  task automatic queue_word(mats_in_t w, int gap);
    timed_word_t e;
    e.word = w;
    e.gap = gap;
    stim_words.insert(stim_words.size(), e);
  endtask

  // Driver: presents queued words, holding each until busy lets it through.
  timed_word_t next_entry;
  mats_in_t    held_word;
  int          gap_left;
  bit          holding = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      holding = 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_results.insert(awaited_results.size(), alarm_outcome(item));
        func_count[item.func]++;
        taken_words++;
        holding = 1'b0;
      end
      if (!(start && busy)) begin
        if (!holding && stim_words.size() != 0) begin
          next_entry = stim_words.pop_front();
          held_word = next_entry.word;
          gap_left = next_entry.gap;
          holding = 1'b1;
        end
        if (holding && gap_left == 0) begin
          start <= 1'b1;
          item <= held_word;
        end else begin
          start <= 1'b0;
          if (holding && gap_left > 0) gap_left--;
          else if (holding && gap_left < 0 && awaited_results.size() == 0) gap_left = 0;
        end
      end
    end
  end

  // Monitor: every result word is strobed for one cycle and checked in order.
  mats_out_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result word with none outstanding: %p", $realtime,
                                       result);
      end else begin
        want = awaited_results.pop_front();
        if (result.pending !== want.pending || result.fired_mask !== want.fired_mask ||
            result.wait_ms !== want.wait_ms || result.host_rearm !== want.host_rearm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch pending %b/%b fired %h/%h wait %0d/%0d rearm %b/%b",
                     $realtime, want.pending, result.pending, want.fired_mask,
                     result.fired_mask, want.wait_ms, result.wait_ms, want.host_rearm,
                     result.host_rearm);
        end
        if (want.fired_mask != '0) firing_ticks++;
        if (want.host_rearm && want.wait_ms == WAIT_MAX) saturated_waits++;
        if (want.host_rearm) host_rearms++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  logic [NOW_W-1:0] clock_us;
  mats_in_t         w;
  int               sel;
  int               gap;
  int               total;

  initial begin
    // Directed opening: reset state, equal and earlier deadlines, wrap, saturation.
    queue_word(mk(FUNC_QUERY, 0, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_TICK, 0, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_START, 0, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_START, 1, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_START, 2, 31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 0), pick_gap());
    queue_word(mk(FUNC_QUERY, 2, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_STOP, 1, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_QUERY, 1, 0, 0, 0), pick_gap());
    // Slot 2 lies more than half the counter ahead, so it counts as already past.
    queue_word(mk(FUNC_TICK, 0, 0, 5, 8'h01), pick_gap());
    queue_word(mk(FUNC_START, 3, 5000, 1000, 0), pick_gap());
    queue_word(mk(FUNC_START, 7, 2_000_000_000, 1000, 0), pick_gap());
    queue_word(mk(FUNC_TICK, 0, 0, 6000, 8'hFF), pick_gap());
    queue_word(mk(FUNC_STOP, 0, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_TICK, 0, 0, 7000, 0), pick_gap());
    queue_word(mk(FUNC_STOP, 3, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_TICK, 0, 0, 7000, 0), pick_gap());
    queue_word(mk(FUNC_STOP, 7, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_START, 5, 1000, 63'h4000_0000_0000_0000, 0), pick_gap());
    queue_word(mk(FUNC_TICK, 0, 0, 63'h3FFF_FFFF_0000_0000, 0), pick_gap());
    queue_word(mk(FUNC_TICK, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF, 0), pick_gap());
    queue_word(mk(FUNC_QUERY, 5, 0, 0, 0), pick_gap());
    queue_word(mk(FUNC_START, 6, 999, 0, 0), pick_gap());
    queue_word(mk(FUNC_START, 6, 1_234_567, 0, 0), pick_gap());
    queue_word(mk(FUNC_START, 1, 500, 0, 0), pick_gap());
    queue_word(mk(FUNC_TICK, 0, 0, 3_000_000, 8'h42), pick_gap());

    // Random part: a mostly advancing clock so that alarms really expire, with jumps,
    // wraps and stray times mixed in.
    clock_us = rand_time();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w = mk(FUNC_QUERY, $urandom_range(SLOTS - 1), PERIOD_W'($urandom), rand_time(),
             MASK_W'($urandom));
      sel = $urandom_range(99);
      if (sel < 30) begin
        w.func = FUNC_START;
        sel = $urandom_range(99);
        if (sel < 40) w.period_us = PERIOD_W'($urandom_range(20000));
        else if (sel < 70) w.period_us = PERIOD_W'($urandom_range(5_000_000));
        else if (sel < 80) w.period_us = sel[0] ? '1 : '0;
        if ($urandom_range(19) != 0) w.now_us = clock_us;
      end else if (sel < 38) begin
        w.func = FUNC_STOP;
      end else if (sel < 55) begin
        w.func = FUNC_QUERY;
      end else begin
        w.func = FUNC_TICK;
        sel = $urandom_range(99);
        if (sel < 50) clock_us = clock_us + $urandom_range(20000);
        else if (sel < 80) clock_us = clock_us + $urandom_range(5_000_000);
        else if (sel < 95) clock_us = clock_us + $urandom;
        else if (sel < 97) clock_us = '1 - $urandom_range(3_000_000);
        else clock_us = rand_time();
        if ($urandom_range(24) != 0) w.now_us = clock_us;
        sel = $urandom_range(9);
        if (sel < 2) w.repeat_mask = '0;
        else if (sel < 4) w.repeat_mask = '1;
      end
      if (n == 0 || n % 180 == 179) gap = -1;
      else if (n >= 700 && n < 800) gap = 0;
      else gap = pick_gap();
      queue_word(w, gap);
    end
    total = stim_words.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (taken_words < total) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Words taken: %0d starts, %0d stops, %0d queries, %0d ticks.",
             func_count[FUNC_START], func_count[FUNC_STOP], func_count[FUNC_QUERY],
             func_count[FUNC_TICK]);
    $display("Ticks with expiries: %0d, host reprogrammings: %0d, saturated waits: %0d.",
             firing_ticks, host_rearms, saturated_waits);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
